[rtl/core/fpt_pkg.sv]
// Shared types, constants and lookup functions for the flow pulse totalizer.
`timescale 1ns / 1ps
`default_nettype none

package fpt_pkg;

    localparam int VOL_W  = 32;   // width of the volume and rate results
    localparam int CNT_W  = 64;   // pulse counter width
    localparam int LIMB_W = 32;   // width of one multiplier operand
    localparam int HALF_W = 2 * LIMB_W;
    localparam int PROD_W = 2 * HALF_W;
    localparam int TKT_W  = 16;
    localparam int IDX_W  = 2;
    localparam int QCNT_W = $clog2(VOL_W);
    localparam int TICK_SHIFT = 15;   // 32768 Hz timer

    localparam logic [39:0] TERA = 40'd1_000_000_000_000;

    typedef enum logic [2:0] {
        CMD_ADD        = 3'd0,
        CMD_RATE       = 3'd1,
        CMD_CLR_ACC    = 3'd2,
        CMD_CLR_TRIP   = 3'd3,
        CMD_CLR_RATE   = 3'd4,
        CMD_NEXT_TKT   = 3'd5
    } cmd_t;

    typedef enum logic [IDX_W-1:0] {
        REG_CAL   = 2'd0,
        REG_VUNIT = 2'd1,
        REG_TUNIT = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] pulse_count;
        logic [15:0] capture_pulses;
        logic [15:0] capture_ticks;
    } fpt_item_t;

    typedef struct packed {
        logic [CNT_W-1:0] accumulated_pulses;
        logic [CNT_W-1:0] trip_pulses;
        logic [VOL_W-1:0] accumulated_volume;
        logic [VOL_W-1:0] trip_volume;
        logic [VOL_W-1:0] flow_rate;
        logic [TKT_W-1:0] ticket;
    } fpt_result_t;

    // Liters per volume unit, times one million.
    function automatic logic [29:0] unit_micro(input logic [2:0] unit);
        logic [29:0] val;
        case (unit)
            3'd1:    val = 30'd158_987_304;
            3'd2:    val = 30'd3_785_410;
            3'd5:    val = 30'd1_000_000_000;
            default: val = 30'd1_000_000;
        endcase
        return val;
    endfunction

    // Seconds per rate time base.
    function automatic logic [16:0] secs_per_unit(input logic [1:0] unit);
        logic [16:0] val;
        case (unit)
            2'd1:    val = 17'd60;
            2'd2:    val = 17'd3600;
            2'd3:    val = 17'd86400;
            default: val = 17'd1;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

[rtl/core/fpt_intf.sv]
// Handshake channel interfaces for the flow pulse totalizer.
`timescale 1ns / 1ps
`default_nettype none

interface fpt_item_if import fpt_pkg::*;;
    logic      valid;
    logic      ready;
    fpt_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface fpt_result_if import fpt_pkg::*;;
    logic        valid;
    logic        ready;
    fpt_result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface fpt_cfg_if import fpt_pkg::*;;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [31:0]      wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

[rtl/core/flow_pulse_totalizer.sv]
// Flow-meter pulse totalizer: top level with the shared multiply/divide sequencer.
//
// The items channel takes one command word at a time: add pulses, capture a
// pulse/tick window and compute the rate, clear either counter, clear the
// rate, or advance the ticket. Each word yields exactly one word on the
// results channel with both 64-bit counters, both volumes x1000, the cached
// rate x1000 and the ticket. The cfg channel writes calibration factor,
// volume unit and time base; it is always ready.
// The volume and rate arithmetic runs through one 32x32 multiplier and one
// 128-bit add/subtract unit. A 64x64 product is built from partial products,
// each multiplied and then accumulated, followed by a store step; a division
// starts with an overflow compare, then runs restoring quotient-bit steps and a
// store, or goes straight to the store when the quotient saturates.
// Ready returns in the cycle after the result is loaded, and no new word is
// accepted until the previous one has left the sequencer. Ready is high only
// while the sequencer is idle. The result sits in an output register, so the
// next word is accepted while it waits; a stalled receiver holds the sequencer
// only at its final step. Reset clears counters, rate and ticket and loads
// calibration 1000, liters and seconds.
`timescale 1ns / 1ps
`default_nettype none

module flow_pulse_totalizer import fpt_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    fpt_item_if.sink      items,
    fpt_result_if.source  results,
    fpt_cfg_if.sink       cfg
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_P,
        S_MUL_A,
        S_DIV_CMP,
        S_DIV_STEP,
        S_STORE,
        S_OUT
    } state_t;

    typedef enum logic [3:0] {
        ST_RATE_A,     // dp * 32768 * secs
        ST_RATE_N,     // rate numerator
        ST_RATE_B,     // (dt - 1) * cal
        ST_RATE_D,     // rate denominator
        ST_RATE_DIV,
        ST_VDEN,       // volume denominator
        ST_VACC_N,
        ST_VACC_DIV,
        ST_VTRIP_N,
        ST_VTRIP_DIV
    } step_t;

    state_t            state_reg, state_next;
    step_t             step_reg, step_next;
    logic [31:0]       cal_reg, cal_next;
    logic [2:0]        vunit_reg, vunit_next;
    logic [1:0]        tunit_reg, tunit_next;
    logic [CNT_W-1:0]  accp_reg, accp_next;
    logic [CNT_W-1:0]  tripp_reg, tripp_next;
    logic [VOL_W-1:0]  rate_reg, rate_next;
    logic [TKT_W-1:0]  tkt_reg, tkt_next;
    logic [15:0]       dp_reg, dp_next;
    logic [15:0]       dt_reg, dt_next;
    logic [HALF_W-1:0] tmp_reg, tmp_next;
    logic [HALF_W-1:0] prod_reg, prod_next;
    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [PROD_W-1:0] num_reg, num_next;
    logic [PROD_W-1:0] den_reg, den_next;
    logic [PROD_W-1:0] rem_reg, rem_next;
    logic [VOL_W-1:0]  quo_reg, quo_next;
    logic [QCNT_W-1:0] qcnt_reg, qcnt_next;
    logic [1:0]        k_reg, k_next;
    logic [VOL_W-1:0]  accv_reg, accv_next;
    logic [VOL_W-1:0]  tripv_reg, tripv_next;
    fpt_result_t       out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    logic [HALF_W-1:0] mul_a, mul_b;
    logic [LIMB_W-1:0] a_part, b_part;
    logic [PROD_W-1:0] prod_sh;
    logic [PROD_W-1:0] add_a, add_b;
    logic              add_sub;
    logic [PROD_W:0]   add_res;
    logic              add_carry;
    logic [PROD_W-1:0] add_sum;

    assign items.ready   = (state_reg == S_IDLE);
    assign cfg.ready     = 1'b1;
    assign results.valid = out_valid_reg;
    assign results.data  = out_reg;

    // Multiplier operands for the current program step.
    always_comb
    begin
        unique case (step_reg)
            ST_RATE_A:
            begin
                mul_a = HALF_W'(dp_reg) << TICK_SHIFT;
                mul_b = HALF_W'(secs_per_unit(tunit_reg));
            end
            ST_RATE_N:
            begin
                mul_a = tmp_reg;
                mul_b = HALF_W'(TERA);
            end
            ST_RATE_B:
            begin
                mul_a = HALF_W'(dt_reg - 16'd1);
                mul_b = HALF_W'(cal_reg);
            end
            ST_RATE_D:
            begin
                mul_a = tmp_reg;
                mul_b = HALF_W'(unit_micro(vunit_reg));
            end
            ST_VDEN:
            begin
                mul_a = HALF_W'(cal_reg);
                mul_b = HALF_W'(unit_micro(vunit_reg));
            end
            ST_VACC_N:
            begin
                mul_a = accp_reg;
                mul_b = HALF_W'(TERA);
            end
            ST_VTRIP_N:
            begin
                mul_a = tripp_reg;
                mul_b = HALF_W'(TERA);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign a_part = k_reg[0] ? mul_a[HALF_W-1:LIMB_W] : mul_a[LIMB_W-1:0];
    assign b_part = k_reg[1] ? mul_b[HALF_W-1:LIMB_W] : mul_b[LIMB_W-1:0];

    always_comb
    begin
        case (k_reg) inside
            2'd0:       prod_sh = PROD_W'(prod_reg);
            2'd1, 2'd2: prod_sh = PROD_W'(prod_reg) << LIMB_W;
            default:    prod_sh = PROD_W'(prod_reg) << HALF_W;
        endcase
    end

    // Shared add/subtract unit: partial-product accumulation and division steps.
    always_comb
    begin
        add_a   = acc_reg;
        add_b   = prod_sh;
        add_sub = 1'b0;
        unique case (state_reg)
            S_DIV_CMP:
            begin
                add_a   = num_reg;
                add_b   = {den_reg[PROD_W-VOL_W-1:0], {VOL_W{1'b0}}};
                add_sub = 1'b1;
            end
            S_DIV_STEP:
            begin
                add_a   = {rem_reg[PROD_W-2:0], quo_reg[VOL_W-1]};
                add_b   = den_reg;
                add_sub = 1'b1;
            end
            default:
            begin
                add_a   = acc_reg;
                add_b   = prod_sh;
                add_sub = 1'b0;
            end
        endcase
    end

    assign add_res   = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)}
                       + (PROD_W + 1)'(add_sub);
    assign add_carry = add_res[PROD_W];
    assign add_sum   = add_res[PROD_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        cal_next       = cal_reg;
        vunit_next     = vunit_reg;
        tunit_next     = tunit_reg;
        accp_next      = accp_reg;
        tripp_next     = tripp_reg;
        rate_next      = rate_reg;
        tkt_next       = tkt_reg;
        dp_next        = dp_reg;
        dt_next        = dt_reg;
        tmp_next       = tmp_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        qcnt_next      = qcnt_reg;
        k_next         = k_reg;
        accv_next      = accv_reg;
        tripv_next     = tripv_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && results.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_CAL:   cal_next   = cfg.wdata;
                REG_VUNIT: vunit_next = cfg.wdata[2:0];
                REG_TUNIT: tunit_next = cfg.wdata[1:0];
                default:   ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (items.valid)
                begin
                    unique case (items.data.cmd)
                        CMD_ADD:
                        begin
                            accp_next  = accp_reg + CNT_W'(items.data.pulse_count);
                            tripp_next = tripp_reg + CNT_W'(items.data.pulse_count);
                        end
                        CMD_RATE:
                        begin
                            if (items.data.capture_ticks <= 16'd1)
                            begin
                                rate_next = '0;
                            end
                        end
                        CMD_CLR_ACC:  accp_next  = '0;
                        CMD_CLR_TRIP: tripp_next = '0;
                        CMD_CLR_RATE: rate_next  = '0;
                        CMD_NEXT_TKT: tkt_next   = tkt_reg + TKT_W'(1);
                        default:      ;
                    endcase
                    dp_next = items.data.capture_pulses;
                    dt_next = items.data.capture_ticks;
                    if (items.data.cmd == CMD_RATE && items.data.capture_ticks > 16'd1)
                    begin
                        step_next = ST_RATE_A;
                    end
                    else
                    begin
                        step_next = ST_VDEN;
                    end
                    acc_next   = '0;
                    k_next     = '0;
                    state_next = S_MUL_P;
                end
            end

            S_MUL_P:
            begin
                prod_next  = HALF_W'(a_part) * HALF_W'(b_part);
                state_next = S_MUL_A;
            end

            S_MUL_A:
            begin
                acc_next = add_sum;
                k_next   = k_reg + 2'd1;
                if (k_reg == 2'd3)
                begin
                    state_next = S_STORE;
                end
                else
                begin
                    state_next = S_MUL_P;
                end
            end

            S_DIV_CMP:
            begin
                // Numerator at or above den * 2^32 means the quotient does not fit;
                // this also covers a zero denominator.
                if (add_carry)
                begin
                    quo_next   = '1;
                    state_next = S_STORE;
                end
                else
                begin
                    rem_next   = num_reg >> VOL_W;
                    quo_next   = num_reg[VOL_W-1:0];
                    qcnt_next  = '0;
                    state_next = S_DIV_STEP;
                end
            end

            S_DIV_STEP:
            begin
                rem_next  = add_carry ? add_sum : add_a;
                quo_next  = {quo_reg[VOL_W-2:0], add_carry};
                qcnt_next = qcnt_reg + QCNT_W'(1);
                if (qcnt_reg == QCNT_W'(VOL_W - 1))
                begin
                    state_next = S_STORE;
                end
            end

            S_STORE:
            begin
                acc_next   = '0;
                k_next     = '0;
                state_next = S_MUL_P;
                unique case (step_reg)
                    ST_RATE_A:
                    begin
                        tmp_next  = acc_reg[HALF_W-1:0];
                        step_next = ST_RATE_N;
                    end
                    ST_RATE_N:
                    begin
                        num_next  = acc_reg;
                        step_next = ST_RATE_B;
                    end
                    ST_RATE_B:
                    begin
                        tmp_next  = acc_reg[HALF_W-1:0];
                        step_next = ST_RATE_D;
                    end
                    ST_RATE_D:
                    begin
                        den_next   = acc_reg;
                        step_next  = ST_RATE_DIV;
                        state_next = S_DIV_CMP;
                    end
                    ST_RATE_DIV:
                    begin
                        rate_next = quo_reg;
                        step_next = ST_VDEN;
                    end
                    ST_VDEN:
                    begin
                        den_next  = acc_reg;
                        step_next = ST_VACC_N;
                    end
                    ST_VACC_N:
                    begin
                        num_next   = acc_reg;
                        step_next  = ST_VACC_DIV;
                        state_next = S_DIV_CMP;
                    end
                    ST_VACC_DIV:
                    begin
                        accv_next = quo_reg;
                        step_next = ST_VTRIP_N;
                    end
                    ST_VTRIP_N:
                    begin
                        num_next   = acc_reg;
                        step_next  = ST_VTRIP_DIV;
                        state_next = S_DIV_CMP;
                    end
                    ST_VTRIP_DIV:
                    begin
                        tripv_next = quo_reg;
                        state_next = S_OUT;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_OUT:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_next.accumulated_pulses = accp_reg;
                    out_next.trip_pulses        = tripp_reg;
                    out_next.accumulated_volume = accv_reg;
                    out_next.trip_volume        = tripv_reg;
                    out_next.flow_rate          = rate_reg;
                    out_next.ticket             = tkt_reg;
                    out_valid_next              = 1'b1;
                    state_next                  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= ST_VDEN;
            cal_reg       <= 32'd1000;
            vunit_reg     <= 3'd4;
            tunit_reg     <= 2'd0;
            accp_reg      <= '0;
            tripp_reg     <= '0;
            rate_reg      <= '0;
            tkt_reg       <= '0;
            dp_reg        <= '0;
            dt_reg        <= '0;
            tmp_reg       <= '0;
            prod_reg      <= '0;
            acc_reg       <= '0;
            num_reg       <= '0;
            den_reg       <= '0;
            rem_reg       <= '0;
            quo_reg       <= '0;
            qcnt_reg      <= '0;
            k_reg         <= '0;
            accv_reg      <= '0;
            tripv_reg     <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            cal_reg       <= cal_next;
            vunit_reg     <= vunit_next;
            tunit_reg     <= tunit_next;
            accp_reg      <= accp_next;
            tripp_reg     <= tripp_next;
            rate_reg      <= rate_next;
            tkt_reg       <= tkt_next;
            dp_reg        <= dp_next;
            dt_reg        <= dt_next;
            tmp_reg       <= tmp_next;
            prod_reg      <= prod_next;
            acc_reg       <= acc_next;
            num_reg       <= num_next;
            den_reg       <= den_next;
            rem_reg       <= rem_next;
            quo_reg       <= quo_next;
            qcnt_reg      <= qcnt_next;
            k_reg         <= k_next;
            accv_reg      <= accv_next;
            tripv_reg     <= tripv_next;
            out_reg       <= out_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire
